/* rtl/core/abbp_pkg.sv */
// Shared types and constants for the bang-bang actuator positioner.
// No dependencies; imported by actuator_bang_bang_positioner_core.
`default_nettype none

package abbp_pkg;

    localparam int SAMPLE_BITS = 15;
    localparam int POS_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;

    // product of a sample and full scale, also the divider's shift register
    localparam int PROD_BITS = SAMPLE_BITS + POS_BITS;
    // multiplier retires two bits of the pot sample per cycle
    localparam int MUL_STEPS = (SAMPLE_BITS + 1) / 2;
    localparam int CNT_BITS  = $clog2(POS_BITS);
    localparam int CMP_BITS  = POS_BITS + 2;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_SET_TARGET  = 2'd1,
        OP_FORCED_STOP = 2'd2,
        OP_RESERVED    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FULL_SCALE = 2'd0,
        CFG_TOLERANCE  = 2'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        RS_IDLE    = 3'd0,
        RS_ACTIVE  = 3'd1,
        RS_TOP     = 3'd2,
        RS_BOTTOM  = 3'd3,
        RS_REACHED = 3'd4,
        RS_FORCED  = 3'd5
    } run_state_t;

    typedef enum logic [1:0] {
        MV_STOPPED = 2'd0,
        MV_EXTEND  = 2'd1,
        MV_RETRACT = 2'd2
    } motion_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_MUL,
        FSM_DIV,
        FSM_DONE
    } fsm_t;

    localparam logic [POS_BITS-1:0] FULL_SCALE_RST = POS_BITS'(1000);
    localparam logic [POS_BITS-1:0] TOLERANCE_RST  = POS_BITS'(10);

    typedef struct packed {
        logic [1:0]             opcode;
        logic [SAMPLE_BITS-1:0] ref_sample;
        logic [SAMPLE_BITS-1:0] pot_sample;
        logic [POS_BITS-1:0]    target;
    } in_item_t;

    typedef struct packed {
        logic                drive_out;
        logic                drive_in;
        logic [2:0]          status;
        logic [POS_BITS-1:0] position_out;
        logic                move_done;
        logic                ref_error;
    } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/actuator_bang_bang_positioner_core.sv */
// Bang-bang actuator positioner: serial ratiometric position plus deadband rule.
// Depends on abbp_pkg (types, widths, codes).
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_ready  | in_item   (abbp_pkg::in_item_t)
// out     | out | out_valid / out_ready| out_item  (abbp_pkg::out_item_t)
// cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
// A tick with a nonzero reference and pot below it passes FSM_IDLE, FSM_MUL,
// FSM_DIV and FSM_DONE from one accept to the next: radix-4 shift-add multiply,
// then one quotient bit a cycle. Every other item goes from FSM_IDLE to FSM_DONE.
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken and worked on. cfg_ready is always high.
// rst_n clears the FSM, output valid and loop state, and loads the config registers' reset values.
`default_nettype none

module actuator_bang_bang_positioner_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire abbp_pkg::in_item_t             in_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output abbp_pkg::out_item_t                 out_item,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [abbp_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [abbp_pkg::POS_BITS-1:0]  cfg_data
);
    import abbp_pkg::*;

    fsm_t                   fsm_reg, fsm_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   out_valid_reg;
    out_item_t              out_item_reg;

    logic [POS_BITS-1:0]    full_scale_reg, tolerance_reg;
    run_state_t             run_state_reg, run_state_next;
    motion_t                motion_reg, motion_next;
    logic [POS_BITS-1:0]    goal_reg, goal_next;
    logic [POS_BITS-1:0]    position_reg, position_next;

    // item capture
    op_t                    op_reg;
    logic [POS_BITS-1:0]    target_reg;
    logic [SAMPLE_BITS-1:0] ref_reg;
    logic [SAMPLE_BITS-1:0] mplier_reg;
    logic [PROD_BITS-1:0]   mcand_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic                   rerr_reg;
    logic                   sat_reg;

    logic                   in_fire, out_free, commit;
    logic                   start_serial;
    logic                   done_flag;
    logic [PROD_BITS-1:0]   addend;
    logic [SAMPLE_BITS:0]   div_trial;
    logic                   div_ge;
    logic [SAMPLE_BITS:0]   div_diff;

    logic signed [CMP_BITS-1:0] pos_s, fs_s, tol_s, goal_s;

    // ------------------------------------------------------------------
    // FSM next state
    // ------------------------------------------------------------------
    always_comb
    begin
        fsm_next = fsm_reg;
        cnt_next = cnt_reg;
        unique case (fsm_reg)
            FSM_IDLE:
            begin
                if (in_fire)
                begin
                    if (start_serial)
                    begin
                        fsm_next = FSM_MUL;
                        cnt_next = CNT_BITS'(MUL_STEPS - 1);
                    end
                    else
                    begin
                        fsm_next = FSM_DONE;
                    end
                end
            end
            FSM_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    fsm_next = FSM_DIV;
                    cnt_next = CNT_BITS'(POS_BITS - 1);
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            FSM_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    fsm_next = FSM_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            FSM_DONE:
            begin
                if (out_free)
                begin
                    fsm_next = FSM_IDLE;
                end
            end
            default:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // FSM outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready = 1'b0;
        commit   = 1'b0;
        unique case (fsm_reg)
            FSM_IDLE: in_ready = 1'b1;
            FSM_MUL:  in_ready = 1'b0;
            FSM_DIV:  in_ready = 1'b0;
            FSM_DONE: commit   = out_free;
            default:  in_ready = 1'b0;
        endcase
    end

    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    // only a tick with pot < ref (so ref nonzero) needs the serial path; pot >= ref saturates
    assign start_serial = (op_t'(in_item.opcode) == OP_TICK)
                       && (in_item.ref_sample != '0)
                       && (in_item.pot_sample < in_item.ref_sample);

    // ------------------------------------------------------------------
    // serial datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        addend = '0;
        if (mplier_reg[0])
        begin
            addend = mcand_reg;
        end
        if (mplier_reg[1])
        begin
            addend = addend + {mcand_reg[PROD_BITS-2:0], 1'b0};
        end
    end

    // remainder sits in the top SAMPLE_BITS of prod_reg, dividend/quotient below
    assign div_trial = {prod_reg[PROD_BITS-1:POS_BITS], prod_reg[POS_BITS-1]};
    assign div_ge    = div_trial >= {1'b0, ref_reg};
    assign div_diff  = div_trial - {1'b0, ref_reg};

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= op_t'(in_item.opcode);
            target_reg <= in_item.target;
            ref_reg    <= in_item.ref_sample;
            mplier_reg <= in_item.pot_sample;
            mcand_reg  <= {{SAMPLE_BITS{1'b0}}, full_scale_reg};
            prod_reg   <= '0;
            rerr_reg   <= (in_item.ref_sample == '0);
            sat_reg    <= (in_item.pot_sample >= in_item.ref_sample);
        end
        else if (fsm_reg == FSM_MUL)
        begin
            prod_reg   <= prod_reg + addend;
            mcand_reg  <= {mcand_reg[PROD_BITS-3:0], 2'b00};
            mplier_reg <= {2'b00, mplier_reg[SAMPLE_BITS-1:2]};
        end
        else if (fsm_reg == FSM_DIV)
        begin
            prod_reg <= {div_ge ? div_diff[SAMPLE_BITS-1:0] : div_trial[SAMPLE_BITS-1:0],
                         prod_reg[POS_BITS-2:0], div_ge};
        end
    end

    // ------------------------------------------------------------------
    // bang-bang rule, evaluated once per item in FSM_DONE
    // ------------------------------------------------------------------
    assign pos_s  = signed'({2'b00, position_next});
    assign fs_s   = signed'({2'b00, full_scale_reg});
    assign tol_s  = signed'({2'b00, tolerance_reg});
    assign goal_s = signed'({2'b00, goal_reg});

    always_comb
    begin
        run_state_next = run_state_reg;
        motion_next    = motion_reg;
        goal_next      = goal_reg;
        position_next  = position_reg;
        done_flag      = 1'b0;
        unique case (op_reg)
            OP_TICK:
            begin
                if (!rerr_reg)
                begin
                    position_next = sat_reg ? full_scale_reg : prod_reg[POS_BITS-1:0];
                end
                if (run_state_reg != RS_ACTIVE)
                begin
                    motion_next = MV_STOPPED;
                end
                else if (pos_s >= fs_s - tol_s && motion_reg == MV_EXTEND)
                begin
                    motion_next    = MV_STOPPED;
                    run_state_next = RS_TOP;
                    done_flag      = 1'b1;
                end
                else if (pos_s <= tol_s && motion_reg == MV_RETRACT)
                begin
                    motion_next    = MV_STOPPED;
                    run_state_next = RS_BOTTOM;
                    done_flag      = 1'b1;
                end
                else if (goal_s + tol_s >= pos_s && pos_s >= goal_s - tol_s)
                begin
                    motion_next    = MV_STOPPED;
                    run_state_next = RS_REACHED;
                    done_flag      = 1'b1;
                end
                else if (goal_s + tol_s <= pos_s)
                begin
                    motion_next = MV_RETRACT;
                end
                else
                begin
                    motion_next = MV_EXTEND;
                end
            end
            OP_SET_TARGET:
            begin
                goal_next      = target_reg;
                run_state_next = RS_ACTIVE;
            end
            OP_FORCED_STOP:
            begin
                if (run_state_reg == RS_ACTIVE)
                begin
                    run_state_next = RS_FORCED;
                    motion_next    = MV_STOPPED;
                    done_flag      = 1'b1;
                end
            end
            OP_RESERVED:
            begin
                done_flag = 1'b0;
            end
            default:
            begin
                done_flag = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control and loop state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= FSM_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            full_scale_reg <= FULL_SCALE_RST;
            tolerance_reg  <= TOLERANCE_RST;
            run_state_reg  <= RS_IDLE;
            motion_reg     <= MV_STOPPED;
            goal_reg       <= '0;
            position_reg   <= '0;
        end
        else
        begin
            fsm_reg <= fsm_next;
            cnt_reg <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FULL_SCALE)
                begin
                    full_scale_reg <= cfg_data;
                end
                else if (cfg_index == CFG_TOLERANCE)
                begin
                    tolerance_reg <= cfg_data;
                end
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                run_state_reg <= run_state_next;
                motion_reg    <= motion_next;
                goal_reg      <= goal_next;
                position_reg  <= position_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_item_reg.drive_out    <= (motion_next == MV_EXTEND);
            out_item_reg.drive_in     <= (motion_next == MV_RETRACT);
            out_item_reg.status       <= run_state_next;
            out_item_reg.position_out <= position_next;
            out_item_reg.move_done    <= done_flag;
            out_item_reg.ref_error    <= (op_reg == OP_TICK) && rerr_reg;
        end
    end

`ifndef SYNTHESIS
    // a finished item must not overwrite a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == FSM_DONE && out_valid_reg && !out_ready) |=> (fsm_reg == FSM_DONE))
        else $error("result overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.drive_out && out_item.drive_in))
        else $error("both bridge pins driven");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.move_done) |->
            (out_item.status != RS_IDLE && out_item.status != RS_ACTIVE
             && !out_item.drive_out && !out_item.drive_in))
        else $error("move_done with running or idle loop");

    // serial path only ever entered from an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fsm_reg == FSM_MUL) |-> $past(in_fire))
        else $error("multiplier started without an item");
`endif

endmodule

`default_nettype wire
